>>> rtl/rpu_pkg.sv
package rpu_pkg;

  // pi/2 in Q1.32, used to scale the quadrant fraction to radians
  localparam logic [32:0] HALF_PI_Q32 = 33'h1_921F_B544;

  // Taylor terms after the leading one, for sine and for cosine
  localparam int TAYLOR_TERMS = 8;

  localparam int PHASE_LAT = 2;
  localparam int TRIG_LAT  = 2 + 2 * TAYLOR_TERMS + 1;
  localparam int POS_LAT   = 2;
  localparam int RPU_LAT   = PHASE_LAT + TRIG_LAT + POS_LAT;

  typedef struct packed {
    logic        [7:0]  slot;
    logic        [31:0] phase;
    logic signed [31:0] spin_rate;
    logic signed [31:0] life;
    logic        [30:0] radius;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic        [15:0] time_step;
  } rpu_req_t;

  typedef struct packed {
    logic        [7:0]  slot_out;
    logic        [31:0] new_phase;
    logic signed [31:0] new_life;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               saturated;
  } rpu_res_t;

  // per-item data that rides alongside the trig unit
  typedef struct packed {
    logic        [7:0]  slot;
    logic        [31:0] new_phase;
    logic signed [31:0] new_life;
    logic               life_sat;
    logic        [30:0] radius;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
  } rpu_side_t;

  // running Taylor state, Q30
  typedef struct packed {
    logic        [1:0]  quad;
    logic        [31:0] th2;
    logic        [31:0] ts;
    logic        [31:0] tc;
    logic signed [33:0] s;
    logic signed [33:0] c;
  } rpu_tay_t;

  // cosine and sine, Q1.17
  typedef struct packed {
    logic signed [18:0] cos_val;
    logic signed [18:0] sin_val;
  } rpu_trig_t;

endpackage

>>> rtl/rpu_phase.sv
module rpu_phase import rpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  rpu_req_t  req_i,
  output logic      valid_o,
  output rpu_side_t side_o
);

  logic               v1_q;
  logic signed [48:0] prod_d, prod_q;
  logic        [31:0] phase_q;
  rpu_side_t          side1_d, side1_q;
  logic signed [32:0] life_diff;
  logic               v2_q;
  logic signed [48:0] prod_rnd;
  rpu_side_t          side2_d, side2_q;

  // stage 1: speed * step, life update
  always_comb begin
    prod_d    = 49'(req_i.spin_rate) * 49'($signed({1'b0, req_i.time_step}));
    life_diff = 33'(req_i.life) - $signed({17'd0, req_i.time_step});
    side1_d           = '0;
    side1_d.slot      = req_i.slot;
    side1_d.radius    = req_i.radius;
    side1_d.center_x  = req_i.center_x;
    side1_d.center_y  = req_i.center_y;
    // only the low side can overflow
    side1_d.life_sat  = life_diff[32] & ~life_diff[31];
    side1_d.new_life  = side1_d.life_sat ? 32'sh8000_0000 : life_diff[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    phase_q <= req_i.phase;
    side1_q <= side1_d;
  end

  // stage 2: round the Q8.40 step half up to Q0.32, wrap onto phase
  always_comb begin
    prod_rnd            = prod_q + 49'sd128;
    side2_d             = side1_q;
    side2_d.new_phase   = phase_q + prod_rnd[39:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
  end

  assign valid_o = v2_q;
  assign side_o  = side2_q;

endmodule

>>> rtl/rpu_term.sv
module rpu_term import rpu_pkg::*; #(
  parameter int N = 1
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  rpu_tay_t tay_i,
  output logic     valid_o,
  output rpu_tay_t tay_o
);

  // divisors of this term and their exact reciprocals for 32-bit dividends
  localparam int          DS  = (2 * N) * (2 * N + 1);
  localparam int          DC  = (2 * N - 1) * (2 * N);
  localparam int          SS  = 32 + $clog2(DS);
  localparam int          SC  = 32 + $clog2(DC);
  localparam logic [32:0] MS  = 33'(((64'd1 << SS) + 64'(DS) - 64'd1) / 64'(DS));
  localparam logic [32:0] MC  = 33'(((64'd1 << SC) + 64'(DC) - 64'd1) / 64'(DC));
  localparam bit          SUB = (N % 2) == 1;

  logic        va_q, vb_q;
  logic [63:0] ps, pc;
  logic [31:0] xs_q, xc_q;
  rpu_tay_t    taya_q, tayb_d, tayb_q;
  logic [64:0] ys, yc;
  logic [31:0] ts_new, tc_new;

  // stage a: previous term times theta squared, back to Q30
  assign ps = 64'(tay_i.ts) * 64'(tay_i.th2);
  assign pc = 64'(tay_i.tc) * 64'(tay_i.th2);

  always_ff @(posedge clk_i) begin
    xs_q   <= ps[61:30];
    xc_q   <= pc[61:30];
    taya_q <= tay_i;
  end

  // stage b: truncating divide by the factor pair, accumulate
  always_comb begin
    ys     = 65'(xs_q) * 65'(MS);
    yc     = 65'(xc_q) * 65'(MC);
    ts_new = 32'(ys >> SS);
    tc_new = 32'(yc >> SC);
    tayb_d    = taya_q;
    tayb_d.ts = ts_new;
    tayb_d.tc = tc_new;
    if (SUB) begin
      tayb_d.s = taya_q.s - $signed({2'b00, ts_new});
      tayb_d.c = taya_q.c - $signed({2'b00, tc_new});
    end else begin
      tayb_d.s = taya_q.s + $signed({2'b00, ts_new});
      tayb_d.c = taya_q.c + $signed({2'b00, tc_new});
    end
  end

  always_ff @(posedge clk_i) begin
    tayb_q <= tayb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  assign valid_o = vb_q;
  assign tay_o   = tayb_q;

endmodule

>>> rtl/rpu_trig.sv
module rpu_trig import rpu_pkg::*; #(
  parameter int TRIG_STAGES = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] phase_i,
  output logic        valid_o,
  output rpu_trig_t   trig_o
);

  localparam int                RW      = TRIG_STAGES - 2;
  localparam int                PW      = TRIG_STAGES + 31;
  localparam logic [31:0]       Q30_ONE = 32'h4000_0000;
  localparam logic signed [20:0] LIM    = 21'sd131072;

  logic [RW-1:0] rh;
  logic [PW-1:0] th_prod;
  logic          va_q, vb_q, vc_q;
  logic [30:0]   tha_q, thb_q;
  logic [1:0]    qa_q, qb_q;
  logic [61:0]   sq;
  logic [31:0]   th2_q;

  logic     tv [TAYLOR_TERMS+1];
  rpu_tay_t tw [TAYLOR_TERMS+1];

  logic signed [33:0] c_rnd, s_rnd;
  logic signed [20:0] c_sh, s_sh;
  logic signed [18:0] cs, ss;
  rpu_trig_t          trig_d, trig_q;

  // stage a: top phase bits past the quadrant scaled by pi/2, rounded to Q30
  assign rh      = phase_i[29 -: RW];
  assign th_prod = PW'(rh) * PW'(HALF_PI_Q32) + (PW'(1) << (TRIG_STAGES - 1));

  always_ff @(posedge clk_i) begin
    tha_q <= th_prod[TRIG_STAGES +: 31];
    qa_q  <= phase_i[31:30];
  end

  // stage b: theta squared, rounded to Q30
  assign sq = 62'(tha_q) * 62'(tha_q) + 62'h2000_0000;

  always_ff @(posedge clk_i) begin
    th2_q <= sq[61:30];
    thb_q <= tha_q;
    qb_q  <= qa_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= tv[TAYLOR_TERMS];
    end
  end

  // leading terms: sin ~ theta, cos ~ 1
  always_comb begin
    tv[0]     = vb_q;
    tw[0].quad = qb_q;
    tw[0].th2  = th2_q;
    tw[0].ts   = {1'b0, thb_q};
    tw[0].tc   = Q30_ONE;
    tw[0].s    = $signed({3'b000, thb_q});
    tw[0].c    = $signed({2'b00, Q30_ONE});
  end

  for (genvar n = 0; n < TAYLOR_TERMS; n++) begin : g_term
    rpu_term #(
      .N (n + 1)
    ) u_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (tv[n]),
      .tay_i   (tw[n]),
      .valid_o (tv[n+1]),
      .tay_o   (tw[n+1])
    );
  end

  // final stage: round to Q17, clamp to one, fold quadrant
  always_comb begin
    c_rnd = tw[TAYLOR_TERMS].c + 34'sd4096;
    s_rnd = tw[TAYLOR_TERMS].s + 34'sd4096;
    c_sh  = c_rnd[33:13];
    s_sh  = s_rnd[33:13];
    if (c_sh > LIM) begin
      cs = 19'(LIM);
    end else if (c_sh < -LIM) begin
      cs = 19'(-LIM);
    end else begin
      cs = c_sh[18:0];
    end
    if (s_sh > LIM) begin
      ss = 19'(LIM);
    end else if (s_sh < -LIM) begin
      ss = 19'(-LIM);
    end else begin
      ss = s_sh[18:0];
    end
    case (tw[TAYLOR_TERMS].quad)
      2'd0: begin
        trig_d.cos_val = cs;
        trig_d.sin_val = ss;
      end
      2'd1: begin
        trig_d.cos_val = -ss;
        trig_d.sin_val = cs;
      end
      2'd2: begin
        trig_d.cos_val = -cs;
        trig_d.sin_val = -ss;
      end
      default: begin
        trig_d.cos_val = ss;
        trig_d.sin_val = -cs;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  assign valid_o = vc_q;
  assign trig_o  = trig_q;

endmodule

>>> rtl/rpu_pos.sv
module rpu_pos import rpu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  rpu_side_t side_i,
  input  rpu_trig_t trig_i,
  output logic      valid_o,
  output rpu_res_t  res_o
);

  localparam logic signed [33:0] MAX32 = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] MIN32 = -34'sh0_8000_0000;

  logic               v1_q, v2_q;
  logic signed [50:0] mx_d, my_d, mx_q, my_q;
  rpu_side_t          side1_q;
  logic signed [50:0] mx_rnd, my_rnd;
  logic signed [33:0] sx, sy;
  logic               sat_x, sat_y;
  rpu_res_t           res_d, res_q;

  // stage 1: radius times cosine and sine
  assign mx_d = 51'($signed({1'b0, side_i.radius})) * 51'(trig_i.cos_val);
  assign my_d = 51'($signed({1'b0, side_i.radius})) * 51'(trig_i.sin_val);

  always_ff @(posedge clk_i) begin
    mx_q    <= mx_d;
    my_q    <= my_d;
    side1_q <= side_i;
  end

  // stage 2: round half up, add center, clamp to int32
  always_comb begin
    mx_rnd = mx_q + 51'sd65536;
    my_rnd = my_q + 51'sd65536;
    sx     = 34'(side1_q.center_x) + mx_rnd[50:17];
    sy     = 34'(side1_q.center_y) + my_rnd[50:17];
    sat_x  = (sx > MAX32) || (sx < MIN32);
    sat_y  = (sy > MAX32) || (sy < MIN32);
    res_d.slot_out  = side1_q.slot;
    res_d.new_phase = side1_q.new_phase;
    res_d.new_life  = side1_q.new_life;
    if (sx > MAX32) begin
      res_d.pos_x = 32'sh7FFF_FFFF;
    end else if (sx < MIN32) begin
      res_d.pos_x = 32'sh8000_0000;
    end else begin
      res_d.pos_x = sx[31:0];
    end
    if (sy > MAX32) begin
      res_d.pos_y = 32'sh7FFF_FFFF;
    end else if (sy < MIN32) begin
      res_d.pos_y = 32'sh8000_0000;
    end else begin
      res_d.pos_y = sy[31:0];
    end
    res_d.saturated = side1_q.life_sat | sat_x | sat_y;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;

endmodule

>>> rtl/radial_particle_update.sv
// Particle orbit update. One particle record goes in per clock and the
// result passes the phase step, the sine/cosine unit and the position
// unit in that order and leaves the block as a one-cycle done_o
// strobe with res_o. Throughput is one item per cycle: busy is always low,
// so start may be held high every cycle. Every stage is registered and the
// pipeline never stalls; the receiver must take each result in the cycle it
// is shown. Most of the depth lies in the Taylor unit: eight terms, each a
// multiply by theta squared followed by a reciprocal multiply for the exact
// truncating divide, two register stages per term. No state carries from
// one item to the next, and reset only clears the valid bits.
module radial_particle_update import rpu_pkg::*; #(
  parameter int TRIG_STAGES = 18
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  rpu_req_t req_i,
  output logic     done_o,
  output rpu_res_t res_o
);

  logic      ph_valid;
  rpu_side_t ph_side;
  logic      trig_valid;
  rpu_trig_t trig;

  // side data delay line, matched to the trig unit
  rpu_side_t side_dly_q [TRIG_LAT];

  // never blocks: every stage advances each cycle
  assign busy = 1'b0;

  // phase advance and life update
  rpu_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .req_i   (req_i),
    .valid_o (ph_valid),
    .side_o  (ph_side)
  );

  // cosine and sine of the new phase
  rpu_trig #(
    .TRIG_STAGES (TRIG_STAGES)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .phase_i (ph_side.new_phase),
    .valid_o (trig_valid),
    .trig_o  (trig)
  );

  always_ff @(posedge clk_i) begin
    side_dly_q[0] <= ph_side;
    for (int i = 1; i < TRIG_LAT; i++) begin
      side_dly_q[i] <= side_dly_q[i-1];
    end
  end

  // position on the circle, saturation flag
  rpu_pos u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trig_valid),
    .side_i  (side_dly_q[TRIG_LAT-1]),
    .trig_i  (trig),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule

>>> rtl/rpu_checker.sv
module rpu_checker import rpu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input rpu_req_t req_i,
  input logic     done_o,
  input rpu_res_t res_o
);

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // each accepted item yields a result
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##RPU_LAT done_o)
    else $error("accepted item gave no result");

  // no result without an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, RPU_LAT))
    else $error("result without item");

  // the result carries the slot of the accepted item it belongs to
  a_slot_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.slot_out == $past(req_i.slot, RPU_LAT))
    else $error("slot mismatch");

  // unclamped life is the plain difference
  a_life: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.saturated ||
                res_o.new_life == $past(req_i.life - $signed({16'd0, req_i.time_step}),
                                        RPU_LAT)))
    else $error("life mismatch");

  // flag set only with some output at a limit
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.saturated) |->
      (res_o.new_life == S32_MIN || res_o.pos_x == S32_MAX || res_o.pos_x == S32_MIN ||
       res_o.pos_y == S32_MAX || res_o.pos_y == S32_MIN))
    else $error("saturated flag without a clamped value");

endmodule

bind radial_particle_update rpu_checker u_rpu_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .res_o  (res_o)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Block-level bench for the particle orbit update pipeline.
// Each accepted particle record is run through a bit-exact predictor here and
// the expected result is queued. Results leave the block as one-cycle done_o
// strobes in issue order, so every strobe is compared against the oldest entry.
module tb_top;
  import rpu_pkg::*;

  localparam int  TRIG_BITS   = 18;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  RANDOM_ITEMS = 920;
  localparam int  BURST_ITEMS  = 100;
  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;
  localparam logic [30:0] RAD_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] RAD_ONE = 31'h0001_0000;  // 1.0 in Q16.16

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rpu_req_t req_i;
  logic     done_o;
  rpu_res_t res_o;

  // expected results, oldest first
  rpu_res_t orbit_expected[$];

  int mismatches;
  int particles_sent;
  int results_checked;
  int clamped_results;
  int quad_hits[4];
  int cycle_count;
  logic [7:0] next_slot;

  radial_particle_update #(.TRIG_STAGES(TRIG_BITS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // v / 2^k rounded half up (toward +inf); arithmetic shift floors
  function automatic longint round_shift(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 131072) return 131072;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // clamp to int32, flag any clamp
  function automatic longint clamp_i32(input longint v, inout bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // cos/sin of a Q0.32 phase, Q1.17, via first-quadrant Taylor sums
  function automatic void unit_circle(input logic [31:0] ph,
                                      output longint co, output longint si);
    logic [31:0] keep;
    logic [31:0] ang;
    logic [1:0]  quad;
    logic [63:0] frac, th, th2, ts, tc;
    longint      s, c, cs, ss;
    keep = 32'hFFFF_FFFF << (32 - TRIG_BITS);
    ang  = ph & keep;
    quad = ang[31:30];
    frac = {34'd0, ang[29:0]};
    // angle in Q2.30 radians
    th  = (frac * 64'(HALF_PI_Q32) + 64'h8000_0000) >> 32;
    th2 = (th * th + 64'h2000_0000) >> 30;
    ts  = th;
    tc  = 64'd1 << 30;
    s   = $signed(ts);
    c   = $signed(tc);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      ts = ((ts * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * th2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s = s - $signed(ts);
        c = c - $signed(tc);
      end else begin
        s = s + $signed(ts);
        c = c + $signed(tc);
      end
    end
    cs = clamp_unit(round_shift(c, 13));
    ss = clamp_unit(round_shift(s, 13));
    case (quad)
      2'd0: begin
        co = cs;  si = ss;
      end
      2'd1: begin
        co = -ss; si = cs;
      end
      2'd2: begin
        co = -cs; si = -ss;
      end
      default: begin
        co = ss;  si = -cs;
      end
    endcase
  endfunction

  function automatic rpu_res_t predict_particle(input rpu_req_t p);
    rpu_res_t   r;
    longint     spd, dt, life, rad, cx, cy, delta, co, si;
    logic [31:0] np;
    bit         hit;
    spd  = $signed(p.spin_rate);
    life = $signed(p.life);
    cx   = $signed(p.center_x);
    cy   = $signed(p.center_y);
    dt   = p.time_step;   // zero-extended
    rad  = p.radius;
    hit  = 1'b0;

    // phase step: Q8.24 * Q0.16 = Q8.40, back to Q0.32 with rounding
    delta = round_shift(spd * dt, 8);
    np    = p.phase + delta[31:0];

    r.slot_out  = p.slot;
    r.new_phase = np;
    r.new_life  = 32'(clamp_i32(life - dt, hit));
    unit_circle(np, co, si);
    r.pos_x     = 32'(clamp_i32(cx + round_shift(rad * co, 17), hit));
    r.pos_y     = 32'(clamp_i32(cy + round_shift(rad * si, 17), hit));
    r.saturated = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rpu_req_t make_particle(input logic [31:0] phase,
                                             input logic [31:0] speed,
                                             input logic [31:0] life,
                                             input logic [30:0] radius,
                                             input logic [31:0] cx,
                                             input logic [31:0] cy,
                                             input logic [15:0] dt);
    rpu_req_t p;
    p.slot          = 8'd0;   // filled in on send
    p.phase         = phase;
    p.spin_rate     = speed;
    p.life          = life;
    p.radius        = radius;
    p.center_x      = cx;
    p.center_y      = cy;
    p.time_step     = dt;
    return p;
  endfunction

  // Random record. Half are physically plausible orbits; the rest are raw
  // noise, clamp-prone extremes, or phases parked on quadrant edges.
  function automatic rpu_req_t rand_particle();
    rpu_req_t p;
    int       pick;
    p.slot          = 8'($urandom);
    p.phase         = $urandom;
    p.spin_rate     = $urandom;
    p.life          = $urandom;
    p.radius        = 31'($urandom);
    p.center_x      = $urandom;
    p.center_y      = $urandom;
    p.time_step     = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      // plausible: a few turns/s, short frames, modest sizes
      p.spin_rate     = 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      p.time_step     = 16'($urandom_range(0, 16'h1000));
      p.life          = 32'($urandom_range(0, 32'h0100_0000));
      p.radius        = 31'($urandom_range(0, 32'h0100_0000));
      p.center_x      = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
      p.center_y      = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    end else if (pick < 7) begin
      // near clamps: big radius, center and life close to the rails
      p.radius   = RAD_MAX - 31'($urandom_range(0, 32'h00FF_FFFF));
      p.center_x = $urandom_range(0, 1) ? I32_MAX - $urandom_range(0, 32'h0FFF_FFFF)
                                        : I32_MIN + $urandom_range(0, 32'h0FFF_FFFF);
      p.center_y = $urandom_range(0, 1) ? I32_MAX - $urandom_range(0, 32'h0FFF_FFFF)
                                        : I32_MIN + $urandom_range(0, 32'h0FFF_FFFF);
      p.life     = I32_MIN + $urandom_range(0, 32'h0001_FFFF);
    end else if (pick < 8) begin
      // no time passes, phase sits on or next to a quadrant edge
      p.time_step = 16'd0;
      p.phase     = {2'($urandom), 30'd0} + 32'($signed($urandom_range(0, 16)) - 8);
    end
    return p;
  endfunction

  // Drive one item and wait for it to be taken. start stays high on return;
  // the next send or an idle burst decides what it does next.
  task automatic send_particle(input rpu_req_t p);
    rpu_res_t want;
    p.slot = next_slot;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= p;
    do @(posedge clk_i); while (busy);
    want = predict_particle(p);
    orbit_expected.push_back(want);
    particles_sent++;
    quad_hits[want.new_phase[31:30]]++;
    if (want.saturated) clamped_results++;
    next_slot = next_slot + 8'd1;
  endtask

  // payload is scrambled while start is low
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      req_i <= rand_particle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    rpu_res_t want;
    if (rst_ni && done_o) begin
      if (orbit_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, res_o);
      end else begin
        want = orbit_expected.pop_front();
        results_checked++;
        check_field("slot_out",  32'(want.slot_out),  32'(res_o.slot_out));
        check_field("new_phase", want.new_phase,      res_o.new_phase);
        check_field("new_life",  want.new_life,       res_o.new_life);
        check_field("pos_x",     want.pos_x,          res_o.pos_x);
        check_field("pos_y",     want.pos_y,          res_o.pos_y);
        check_field("saturated", 32'(want.saturated), 32'(res_o.saturated));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, orbit_expected.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // all-zero, all-max and all-min records, plus one of alternating bits
  task automatic test_field_extremes();
    send_particle(make_particle(32'd0, 32'd0, 32'd0, 31'd0, 32'd0, 32'd0, 16'd0));
    send_particle(make_particle(32'hFFFF_FFFF, I32_MAX, I32_MAX, RAD_MAX,
                                I32_MAX, I32_MAX, 16'hFFFF));
    send_particle(make_particle(32'hFFFF_FFFF, I32_MIN, I32_MIN, 31'd0,
                                I32_MIN, I32_MIN, 16'hFFFF));
    send_particle(make_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                31'h2AAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA));
  endtask

  // zero time step: phase and life held, position still computed
  task automatic test_zero_step();
    send_particle(make_particle(32'h1234_5678, I32_MAX, 32'h0003_0000, RAD_ONE,
                                32'd0, 32'd0, 16'd0));
    send_particle(make_particle(32'hC000_0000, I32_MIN, 32'hFFFF_0000, 31'h0100_0000,
                                32'h0010_0000, 32'hFFF0_0000, 16'd0));
  endtask

  // life goes negative, then pins at the int32 floor
  task automatic test_life_floor();
    send_particle(make_particle(32'd0, 32'd0, 32'h0000_4000, RAD_ONE,
                                32'd0, 32'd0, 16'h8000));
    send_particle(make_particle(32'd0, 32'd0, 32'hFFFF_FFFB, RAD_ONE,
                                32'd0, 32'd0, 16'h8000));
    send_particle(make_particle(32'd0, 32'd0, I32_MIN + 32'd10, RAD_ONE,
                                32'd0, 32'd0, 16'hFFFF));
    send_particle(make_particle(32'd0, 32'd0, I32_MIN + 32'hFFFF, RAD_ONE,
                                32'd0, 32'd0, 16'hFFFF));
  endtask

  // radius/center big enough to push each coordinate past either rail
  task automatic test_position_clamp();
    send_particle(make_particle(32'h0000_0000, 32'd0, 32'd0, RAD_MAX,
                                I32_MAX, 32'd0, 16'd0));
    send_particle(make_particle(32'h4000_0000, 32'd0, 32'd0, RAD_MAX,
                                32'd0, I32_MAX, 16'd0));
    send_particle(make_particle(32'h8000_0000, 32'd0, 32'd0, RAD_MAX,
                                I32_MIN, 32'd0, 16'd0));
    send_particle(make_particle(32'hC000_0000, 32'd0, 32'd0, RAD_MAX,
                                32'd0, I32_MIN, 16'd0));
  endtask

  // unit circle around the origin, two points in each quadrant (a third of the
  // way in and at its end), plus a backward wrap through zero
  task automatic test_quadrants();
    for (int q = 0; q < 4; q++) begin
      send_particle(make_particle({2'(q), 30'h1555_5555}, 32'd0, 32'd0, RAD_ONE,
                                  32'd0, 32'd0, 16'd0));
      send_particle(make_particle({2'(q), 30'h3FFF_FFFF}, 32'd0, 32'd0, RAD_ONE,
                                  32'd0, 32'd0, 16'd0));
    end
    send_particle(make_particle(32'h0000_0100, 32'hFF00_0000, 32'd0, RAD_ONE,
                                32'd0, 32'd0, 16'h0100));
  endtask

  // phase delta lands exactly on a half step, both signs
  task automatic test_phase_rounding();
    send_particle(make_particle(32'd0, 32'd1, 32'd0, RAD_ONE, 32'd0, 32'd0, 16'd128));
    send_particle(make_particle(32'd0, 32'hFFFF_FFFF, 32'd0, RAD_ONE,
                                32'd0, 32'd0, 16'd128));
  endtask

  // sender stops until the pipe has drained, then resumes
  task automatic test_drain_pause();
    repeat (30) send_particle(rand_particle());
    idle_cycles(1);
    wait (orbit_expected.size() == 0);
    repeat (30) send_particle(rand_particle());
  endtask

  // bulk random traffic; each chunk of 40 is picked at random as gappy or gap-free
  task automatic test_random_traffic();
    bit gappy;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) gappy = $urandom_range(0, 2) != 0;
      if (gappy && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 17));
      send_particle(rand_particle());
    end
  endtask

  // closing stretch at full rate, no idling at all
  task automatic test_back_to_back();
    repeat (BURST_ITEMS) send_particle(rand_particle());
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    req_i           = '0;
    mismatches      = 0;
    particles_sent  = 0;
    results_checked = 0;
    clamped_results = 0;
    cycle_count     = 0;
    next_slot       = 8'd0;
    for (int q = 0; q < 4; q++) quad_hits[q] = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_zero_step();
    test_life_floor();
    test_position_clamp();
    test_quadrants();
    test_phase_rounding();
    test_drain_pause();
    test_random_traffic();
    test_back_to_back();

    @(negedge clk_i);
    start <= 1'b0;
    wait (orbit_expected.size() == 0);
    repeat (RPU_LAT + 8) @(posedge clk_i);

    $display("Covered %0d particle records, %0d results checked, %0d with a clamp.",
             particles_sent, results_checked, clamped_results);
    $display("New phase by quadrant: %0d / %0d / %0d / %0d, %0d mismatches.",
             quad_hits[0], quad_hits[1], quad_hits[2], quad_hits[3], mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
